// ===== rtl/ttcs_pkg.sv =====
`timescale 1ns / 1ps
package ttcs_pkg;

  localparam int VIEW_WIDTH_DEF  = 256;
  localparam int VIEW_HEIGHT_DEF = 256;

  // Pipeline depths, counted in registers from the stage that feeds each unit.
  localparam int VTX_LAT   = 2;
  localparam int FACE_LAT  = 15;
  localparam int PIX_LAT   = 20;
  localparam int OUT_DLY   = PIX_LAT - FACE_LAT;
  localparam int PIPE_LAT  = VTX_LAT + PIX_LAT;

  localparam int SHADE_BITS  = 8;
  localparam int SHADE_SCALE = 65025;
  localparam int ZERO_Z_BIAS = 65536;
  localparam int ZERO_Z_DEN  = 131072;

  localparam logic [2:0] REG_ROT_X       = 3'd0;
  localparam logic [2:0] REG_ROT_Y       = 3'd1;
  localparam logic [2:0] REG_ROT_Z       = 3'd2;
  localparam logic [2:0] REG_TRANSLATION = 3'd3;
  localparam logic [2:0] REG_CAMERA      = 3'd4;
  localparam logic [2:0] REG_PROJECTION  = 3'd5;

  typedef logic signed [15:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

  typedef struct packed {
    logic [47:0] rot_x;
    logic [47:0] rot_y;
    logic [47:0] rot_z;
    logic [47:0] trans;
    logic [47:0] cam;
    logic [63:0] proj;
  } cfg_t;

  typedef struct packed {
    coord_t vertex0_x;
    coord_t vertex0_y;
    coord_t vertex0_z;
    coord_t vertex1_x;
    coord_t vertex1_y;
    coord_t vertex1_z;
    coord_t vertex2_x;
    coord_t vertex2_y;
    coord_t vertex2_z;
  } in_t;

  typedef struct packed {
    coord_t     screen_x0;
    coord_t     screen_y0;
    coord_t     screen_x1;
    coord_t     screen_y1;
    coord_t     screen_x2;
    coord_t     screen_y2;
    logic [7:0] shade;
  } out_t;

endpackage

// ===== rtl/ttcs_vertex_lane.sv =====
`timescale 1ns / 1ps
module ttcs_vertex_lane import ttcs_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  vec3_t v_i,
  input  cfg_t  cfg_i,
  output vec3_t t_o
);

  logic [47:0]        rows [3];
  coord_t             comp [3];
  logic signed [31:0] prod_q [3][3];
  coord_t             t_d [3];
  coord_t             t_q [3];

  assign rows[0] = cfg_i.rot_x;
  assign rows[1] = cfg_i.rot_y;
  assign rows[2] = cfg_i.rot_z;
  assign comp[0] = v_i.x;
  assign comp[1] = v_i.y;
  assign comp[2] = v_i.z;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 3; a++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[a][c] <= comp[c] * $signed(rows[a][16*c +: 16]);
        end
      end
    end
  end

  // Round to Q7.8, add the offset and saturate to 16 bits.
  always_comb begin
    logic signed [33:0] acc;
    logic signed [20:0] sum;
    for (int a = 0; a < 3; a++) begin
      acc = 34'(prod_q[a][0]) + 34'(prod_q[a][1]) + 34'(prod_q[a][2]) + 34'sd8192;
      sum = 21'(20'(acc >>> 14)) + 21'($signed(cfg_i.trans[16*a +: 16]));
      if (sum > 21'sd32767) begin
        t_d[a] = 16'sh7fff;
      end else if (sum < -21'sd32768) begin
        t_d[a] = 16'sh8000;
      end else begin
        t_d[a] = 16'(sum);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q <= t_d;
    end
  end

  assign t_o.x = t_q[0];
  assign t_o.y = t_q[1];
  assign t_o.z = t_q[2];

endmodule

// ===== rtl/ttcs_face.sv =====
`timescale 1ns / 1ps
module ttcs_face import ttcs_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  vec3_t       t0_i,
  input  vec3_t       t1_i,
  input  vec3_t       t2_i,
  input  logic [47:0] cam_i,
  output logic        keep_o,
  output logic [7:0]  shade_o
);

  logic signed [16:0] l1x, l1y, l1z, l2x, l2y, l2z;
  logic signed [33:0] pa_q, pb_q, pc_q, pd_q, pe_q, pf_q;
  logic signed [16:0] e1_q [3];
  logic signed [16:0] e2_q [3];
  logic signed [34:0] n_q [3];
  logic signed [51:0] dp_q [3];
  logic [34:0]        m3_q [3];
  logic               neg3_q;
  logic [34:0]        m4_q [3];
  logic [3:0]         sh_q;
  logic               neg4_q, keep4_q;
  logic [34:0]        mx;
  logic [3:0]         sh_d;
  logic [19:0]        ms_q [3];
  logic               neg5_q, keep5_q;
  logic [39:0]        sq_q [3];
  logic               neg6_q, keep6_q;

  logic [7:0]  s_q    [SHADE_BITS+1];
  logic [57:0] p_q    [SHADE_BITS+1];
  logic [41:0] sum_q  [SHADE_BITS+1];
  logic [55:0] rhs_q  [SHADE_BITS+1];
  logic        neg_q  [SHADE_BITS+1];
  logic        keep_q [SHADE_BITS+1];

  assign l1x = 17'(t1_i.x) - 17'(t0_i.x);
  assign l1y = 17'(t1_i.y) - 17'(t0_i.y);
  assign l1z = 17'(t1_i.z) - 17'(t0_i.z);
  assign l2x = 17'(t2_i.x) - 17'(t0_i.x);
  assign l2y = 17'(t2_i.y) - 17'(t0_i.y);
  assign l2z = 17'(t2_i.z) - 17'(t0_i.z);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= 34'(l1y) * 34'(l2z);
      pb_q <= 34'(l1z) * 34'(l2y);
      pc_q <= 34'(l1z) * 34'(l2x);
      pd_q <= 34'(l1x) * 34'(l2z);
      pe_q <= 34'(l1x) * 34'(l2y);
      pf_q <= 34'(l1y) * 34'(l2x);
      e1_q[0] <= 17'(t0_i.x) - 17'($signed(cam_i[15:0]));
      e1_q[1] <= 17'(t0_i.y) - 17'($signed(cam_i[31:16]));
      e1_q[2] <= 17'(t0_i.z) - 17'($signed(cam_i[47:32]));

      n_q[0] <= 35'(pa_q) - 35'(pb_q);
      n_q[1] <= 35'(pc_q) - 35'(pd_q);
      n_q[2] <= 35'(pe_q) - 35'(pf_q);
      e2_q   <= e1_q;

      for (int a = 0; a < 3; a++) begin
        dp_q[a] <= 52'(n_q[a]) * 52'(e2_q[a]);
        m3_q[a] <= n_q[a][34] ? 35'(-n_q[a]) : 35'(n_q[a]);
      end
      neg3_q <= n_q[2][34];

      keep4_q <= $signed(54'(dp_q[0]) + 54'(dp_q[1]) + 54'(dp_q[2])) < 54'sd0;
      m4_q    <= m3_q;
      sh_q    <= sh_d;
      neg4_q  <= neg3_q;

      for (int a = 0; a < 3; a++) begin
        ms_q[a] <= 20'(m4_q[a] >> sh_q);
      end
      neg5_q  <= neg4_q;
      keep5_q <= keep4_q;

      for (int a = 0; a < 3; a++) begin
        sq_q[a] <= 40'(ms_q[a]) * 40'(ms_q[a]);
      end
      neg6_q  <= neg5_q;
      keep6_q <= keep5_q;

      sum_q[0]  <= 42'(sq_q[0]) + 42'(sq_q[1]) + 42'(sq_q[2]);
      rhs_q[0]  <= 56'(sq_q[2]) * 56'(SHADE_SCALE);
      s_q[0]    <= '0;
      p_q[0]    <= '0;
      neg_q[0]  <= neg6_q;
      keep_q[0] <= keep6_q;
    end
  end

  // Common right shift that brings the largest normal magnitude below 2^20.
  always_comb begin
    mx = m3_q[0];
    if (m3_q[1] > mx) mx = m3_q[1];
    if (m3_q[2] > mx) mx = m3_q[2];
    sh_d = '0;
    for (int k = 0; k < 15; k++) begin
      if (mx >= (35'd1 << (20 + k))) sh_d = sh_d + 4'd1;
    end
  end

  // One shade bit per stage. p_q tracks s*s*sum so that each trial needs a
  // single product: (s+b)^2*sum = s^2*sum + (2s+b)*b*sum.
  for (genvar g = 0; g < SHADE_BITS; g++) begin : g_bit
    localparam int J = SHADE_BITS - 1 - g;
    logic [8:0]  f;
    logic [50:0] inc;
    logic [57:0] cand;

    assign f    = {s_q[g], 1'b0} | 9'(1 << J);
    assign inc  = 51'(f) * 51'(sum_q[g]);
    assign cand = p_q[g] + (58'(inc) << J);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cand <= 58'(rhs_q[g])) begin
          s_q[g+1] <= s_q[g] | 8'(1 << J);
          p_q[g+1] <= cand;
        end else begin
          s_q[g+1] <= s_q[g];
          p_q[g+1] <= p_q[g];
        end
        sum_q[g+1]  <= sum_q[g];
        rhs_q[g+1]  <= rhs_q[g];
        neg_q[g+1]  <= neg_q[g];
        keep_q[g+1] <= keep_q[g];
      end
    end
  end

  assign keep_o  = keep_q[SHADE_BITS];
  assign shade_o = neg_q[SHADE_BITS] ? s_q[SHADE_BITS] : 8'd0;

endmodule

// ===== rtl/ttcs_pixel_lane.sv =====
`timescale 1ns / 1ps
module ttcs_pixel_lane import ttcs_pkg::*; #(
  parameter int DIM = VIEW_WIDTH_DEF
) (
  input  logic   clk_i,
  input  logic   en_i,
  input  coord_t c_i,
  input  coord_t scale_i,
  input  coord_t z_i,
  output coord_t px_o
);

  localparam int DIM_W = $clog2(DIM + 1);
  localparam int SUM_W = 33;
  localparam int NUM_W = SUM_W + DIM_W + 1;
  localparam int DM_W  = 25;
  localparam int DEN_W = DM_W + 1;
  localparam int QW    = 16;
  localparam int RW    = (NUM_W > DM_W + QW) ? NUM_W : DM_W + QW;

  logic signed [31:0]      prod_q;
  coord_t                  z_q;
  logic signed [SUM_W-1:0] addend, total;
  logic signed [NUM_W-1:0] num_d, num_q;
  logic signed [DEN_W-1:0] den_d, den_q;
  logic [NUM_W-1:0]        nmag;
  logic [DM_W-1:0]         dmag;

  logic [RW-1:0]   r_q  [QW+1];
  logic [DM_W-1:0] dm_q [QW+1];
  logic [QW-1:0]   q_q  [QW+1];
  logic            ng_q [QW+1];
  logic            ov_q [QW+1];

  coord_t px_d, px_q;
  logic [QW-1:0] qm;

  always_comb begin
    if (z_q == 16'sd0) begin
      addend = SUM_W'(ZERO_Z_BIAS);
      den_d  = DEN_W'(ZERO_Z_DEN);
    end else begin
      addend = SUM_W'(z_q) <<< 8;
      den_d  = DEN_W'(z_q) <<< 9;
    end
    total = SUM_W'(prod_q) + addend;
    num_d = NUM_W'(total) * NUM_W'(DIM);
  end

  assign nmag = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
  assign dmag = den_q[DEN_W-1] ? DM_W'(-den_q) : DM_W'(den_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= c_i * scale_i;
      z_q     <= z_i;
      num_q   <= num_d;
      den_q   <= den_d;
      r_q[0]  <= RW'(nmag);
      dm_q[0] <= dmag;
      q_q[0]  <= '0;
      ng_q[0] <= num_q[NUM_W-1] ^ den_q[DEN_W-1];
      // A quotient of 2^16 or more saturates either way.
      ov_q[0] <= RW'(nmag) >= (RW'(dmag) << QW);
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar g = 0; g < QW; g++) begin : g_div
    localparam int I = QW - 1 - g;
    logic [RW-1:0] trial;

    assign trial = RW'(dm_q[g]) << I;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (r_q[g] >= trial) begin
          r_q[g+1] <= r_q[g] - trial;
          q_q[g+1] <= q_q[g] | QW'(1 << I);
        end else begin
          r_q[g+1] <= r_q[g];
          q_q[g+1] <= q_q[g];
        end
        dm_q[g+1] <= dm_q[g];
        ng_q[g+1] <= ng_q[g];
        ov_q[g+1] <= ov_q[g];
      end
    end
  end

  assign qm = q_q[QW];

  always_comb begin
    if (ng_q[QW]) begin
      if (ov_q[QW] || qm > 16'd32768) px_d = 16'sh8000;
      else px_d = 16'(17'sd0 - 17'({1'b0, qm}));
    end else begin
      if (ov_q[QW] || qm > 16'd32767) px_d = 16'sh7fff;
      else px_d = qm;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= px_d;
    end
  end

  assign px_o = px_q;

endmodule

// ===== rtl/triangle_transform_cull_shade.sv =====
`timescale 1ns / 1ps
// Triangle geometry pipeline: rotate and translate three vertices, cull
// back-facing and degenerate triangles, project to pixels and flat shade.
// One triangle transaction is accepted every cycle; a kept triangle leaves
// through the vertex lanes and then the pixel lanes (product, scaling,
// sign split, a 16-stage one-bit-per-stage divider and saturation). Culled
// triangles produce no output transaction. When the output is stalled the
// whole pipeline holds and the input stalls as well. Registers live at byte
// address 8*index on the 64-bit configuration port and must be written while
// the pipeline is empty.
module triangle_transform_cull_shade import ttcs_pkg::*; #(
  parameter int VIEW_WIDTH  = VIEW_WIDTH_DEF,
  parameter int VIEW_HEIGHT = VIEW_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  cfg_t          cfg_q;
  logic [2:0]    reg_idx;
  logic          cfg_wr;
  logic          en;
  logic [PIPE_LAT-1:0] vld_q;

  vec3_t  vin [3];
  vec3_t  tv [3];
  logic   keep;
  logic [7:0] shade;
  logic [7:0] shade_dly_q [OUT_DLY];
  logic       keep_dly_q  [OUT_DLY];
  coord_t     px [3];
  coord_t     py [3];

  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot_x <= 48'd16384;
      cfg_q.rot_y <= 48'd16384 << 16;
      cfg_q.rot_z <= 48'd16384 << 32;
      cfg_q.trans <= '0;
      cfg_q.cam   <= '0;
      cfg_q.proj  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ROT_X:       cfg_q.rot_x <= pwdata[47:0];
        REG_ROT_Y:       cfg_q.rot_y <= pwdata[47:0];
        REG_ROT_Z:       cfg_q.rot_z <= pwdata[47:0];
        REG_TRANSLATION: cfg_q.trans <= pwdata[47:0];
        REG_CAMERA:      cfg_q.cam   <= pwdata[47:0];
        REG_PROJECTION:  cfg_q.proj  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROT_X:       prdata = 64'(cfg_q.rot_x);
      REG_ROT_Y:       prdata = 64'(cfg_q.rot_y);
      REG_ROT_Z:       prdata = 64'(cfg_q.rot_z);
      REG_TRANSLATION: prdata = 64'(cfg_q.trans);
      REG_CAMERA:      prdata = 64'(cfg_q.cam);
      REG_PROJECTION:  prdata = cfg_q.proj;
      default:         prdata = '0;
    endcase
  end

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  assign vin[0] = '{x: in_data_i.vertex0_x, y: in_data_i.vertex0_y, z: in_data_i.vertex0_z};
  assign vin[1] = '{x: in_data_i.vertex1_x, y: in_data_i.vertex1_y, z: in_data_i.vertex1_z};
  assign vin[2] = '{x: in_data_i.vertex2_x, y: in_data_i.vertex2_y, z: in_data_i.vertex2_z};

  for (genvar k = 0; k < 3; k++) begin : g_vtx
    ttcs_vertex_lane u_vtx (
      .clk_i (clk_i),
      .en_i  (en),
      .v_i   (vin[k]),
      .cfg_i (cfg_q),
      .t_o   (tv[k])
    );

    ttcs_pixel_lane #(.DIM(VIEW_WIDTH)) u_px (
      .clk_i   (clk_i),
      .en_i    (en),
      .c_i     (tv[k].x),
      .scale_i ($signed(cfg_q.proj[15:0])),
      .z_i     (tv[k].z),
      .px_o    (px[k])
    );

    ttcs_pixel_lane #(.DIM(VIEW_HEIGHT)) u_py (
      .clk_i   (clk_i),
      .en_i    (en),
      .c_i     (tv[k].y),
      .scale_i ($signed(cfg_q.proj[31:16])),
      .z_i     (tv[k].z),
      .px_o    (py[k])
    );
  end

  ttcs_face u_face (
    .clk_i   (clk_i),
    .en_i    (en),
    .t0_i    (tv[0]),
    .t1_i    (tv[1]),
    .t2_i    (tv[2]),
    .cam_i   (cfg_q.cam),
    .keep_o  (keep),
    .shade_o (shade)
  );

  // The face result is ready before the pixel lanes finish.
  always_ff @(posedge clk_i) begin
    if (en) begin
      shade_dly_q[0] <= shade;
      keep_dly_q[0]  <= keep;
      for (int i = 1; i < OUT_DLY; i++) begin
        shade_dly_q[i] <= shade_dly_q[i-1];
        keep_dly_q[i]  <= keep_dly_q[i-1];
      end
    end
  end

  assign out_valid_o = vld_q[PIPE_LAT-1] && keep_dly_q[OUT_DLY-1];

  assign out_data_o.screen_x0 = px[0];
  assign out_data_o.screen_y0 = py[0];
  assign out_data_o.screen_x1 = px[1];
  assign out_data_o.screen_y1 = py[1];
  assign out_data_o.screen_x2 = px[2];
  assign out_data_o.screen_y2 = py[2];
  assign out_data_o.shade     = shade_dly_q[OUT_DLY-1];

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(vld_q))
    else $error("pipeline moved while the output was stalled");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[0])
    else $error("accepted transaction did not enter the pipeline");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && reg_idx == REG_CAMERA |=> cfg_q.cam == $past(pwdata[47:0]))
    else $error("camera register write lost");

endmodule
